// File: sv/alle_pkg.sv
// Shared constants, codes and transaction types for the array linked list engine.
package alle_pkg;

   localparam int unsigned DEPTH  = 1024;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned PTR_W  = $clog2(DEPTH + 1);
   localparam int unsigned POS_W  = 11;
   localparam int unsigned VAL_W  = 32;

   localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(DEPTH);

   typedef enum logic [1:0] {
      KIND_INS_HEAD  = 2'd0,
      KIND_INS_AFTER = 2'd1,
      KIND_DEL_AFTER = 2'd2,
      KIND_READ_NEXT = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_BAD_POS = 3'd2,
      ST_NO_DEL  = 3'd3,
      ST_EMPTY   = 3'd4
   } status_type;

   typedef struct packed {
      kind_type                 kind;
      logic [POS_W-1:0]         position;
      logic signed [VAL_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0]  read_value;
      logic                     last;
      status_type               status;
   } rsp_type;

endpackage

// File: sv/array_linked_list_engine.sv
// Sequence: an accepted transaction enters S_EXEC; head insert and rejected requests go straight to S_DONE,
// read next, head delete and a delete whose reference link is null pass S_LINK1 first, insert after passes
// S_LINK1 and S_WRITE2, delete after S_LINK1 and S_LINK2. One transaction at a time: the next is taken only
// back in S_IDLE, after the dependent link memory reads and write-back; the last response may still drain.
// Reset (synchronous, active high) empties the list and ends the walk at once; the
// value and link memories are not cleared, no entry is read before it is written.
module array_linked_list_engine
   import alle_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_EXEC   = 6'b000010,
      S_LINK1  = 6'b000100,
      S_LINK2  = 6'b001000,
      S_WRITE2 = 6'b010000,
      S_DONE   = 6'b100000
   } fsm_type;

   fsm_type           state_ff, state_in;
   req_type           req_ff;
   rsp_type           res_ff, res_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  used_ff, used_in;
   logic [PTR_W-1:0]  cursor_ff, cursor_in;
   logic              active_ff, active_in;

   // memories
   logic [VAL_W-1:0]  val_mem [DEPTH];
   logic [PTR_W-1:0]  lnk_mem [DEPTH];
   logic [VAL_W-1:0]  val_q;
   logic [PTR_W-1:0]  lnk_q;
   logic              val_we, val_re, lnk_we, lnk_re;
   logic [ADDR_W-1:0] val_waddr, val_raddr, lnk_waddr, lnk_raddr;
   logic [VAL_W-1:0]  val_wdata;
   logic [PTR_W-1:0]  lnk_wdata;

   logic [ADDR_W-1:0] ref_addr, new_addr;
   logic [PTR_W-1:0]  walk_start;
   logic              is_full, pos_beyond;

   assign ref_addr   = ADDR_W'(req_ff.position - POS_W'(1));
   assign new_addr   = used_ff[ADDR_W-1:0];
   assign is_full    = (used_ff == NULL_PTR);
   assign pos_beyond = (int'(req_ff.position) > int'(used_ff));
   assign walk_start = active_ff ? cursor_ff : head_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      used_in   = used_ff;
      cursor_in = cursor_ff;
      active_in = active_ff;
      res_in    = res_ff;
      val_we    = 1'b0;
      val_re    = 1'b0;
      val_waddr = new_addr;
      val_raddr = walk_start[ADDR_W-1:0];
      val_wdata = req_ff.value;
      lnk_we    = 1'b0;
      lnk_re    = 1'b0;
      lnk_waddr = ref_addr;
      lnk_raddr = ref_addr;
      lnk_wdata = lnk_q;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            res_in.read_value = '0;
            res_in.last       = 1'b0;
            res_in.status     = ST_OK;
            state_in          = S_DONE;
            case (req_ff.kind)
               KIND_INS_HEAD: begin
                  if (is_full) begin
                     res_in.status = ST_FULL;
                  end else begin
                     val_we    = 1'b1;
                     lnk_we    = 1'b1;
                     lnk_waddr = new_addr;
                     lnk_wdata = head_ff;
                     head_in   = used_ff;
                     used_in   = used_ff + PTR_W'(1);
                     active_in = 1'b0;
                     cursor_in = NULL_PTR;
                  end
               end
               KIND_INS_AFTER: begin
                  if (req_ff.position == '0 || pos_beyond) begin
                     res_in.status = ST_BAD_POS;
                  end else if (is_full) begin
                     res_in.status = ST_FULL;
                  end else begin
                     val_we   = 1'b1;
                     lnk_re   = 1'b1;
                     state_in = S_LINK1;
                  end
               end
               KIND_DEL_AFTER: begin
                  if (req_ff.position == '0) begin
                     if (head_ff == NULL_PTR) begin
                        res_in.status = ST_NO_DEL;
                     end else begin
                        lnk_re    = 1'b1;
                        lnk_raddr = head_ff[ADDR_W-1:0];
                        state_in  = S_LINK1;
                     end
                  end else if (pos_beyond) begin
                     res_in.status = ST_BAD_POS;
                  end else begin
                     lnk_re   = 1'b1;
                     state_in = S_LINK1;
                  end
               end
               KIND_READ_NEXT: begin
                  if (int'(walk_start) >= int'(DEPTH)) begin
                     res_in.status = ST_EMPTY;
                     active_in     = 1'b0;
                     cursor_in     = NULL_PTR;
                  end else begin
                     cursor_in = walk_start;
                     lnk_re    = 1'b1;
                     lnk_raddr = walk_start[ADDR_W-1:0];
                     val_re    = 1'b1;
                     state_in  = S_LINK1;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_LINK1: begin
            state_in = S_DONE;
            case (req_ff.kind)
               KIND_INS_AFTER: begin
                  // new node inherits the reference node's link
                  lnk_we    = 1'b1;
                  lnk_waddr = new_addr;
                  lnk_wdata = lnk_q;
                  state_in  = S_WRITE2;
               end
               KIND_DEL_AFTER: begin
                  if (req_ff.position == '0) begin
                     head_in   = lnk_q;
                     active_in = 1'b0;
                     cursor_in = NULL_PTR;
                  end else if (lnk_q == NULL_PTR) begin
                     res_in.status = ST_NO_DEL;
                  end else begin
                     lnk_re    = 1'b1;
                     lnk_raddr = lnk_q[ADDR_W-1:0];
                     state_in  = S_LINK2;
                  end
               end
               KIND_READ_NEXT: begin
                  res_in.read_value = val_q;
                  if (lnk_q == NULL_PTR) begin
                     res_in.last = 1'b1;
                     active_in   = 1'b0;
                     cursor_in   = NULL_PTR;
                  end else begin
                     cursor_in = lnk_q;
                     active_in = 1'b1;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_LINK2: begin
            // reference node skips over its successor
            lnk_we    = 1'b1;
            lnk_waddr = ref_addr;
            lnk_wdata = lnk_q;
            active_in = 1'b0;
            cursor_in = NULL_PTR;
            state_in  = S_DONE;
         end
         S_WRITE2: begin
            lnk_we    = 1'b1;
            lnk_waddr = ref_addr;
            lnk_wdata = used_ff;
            used_in   = used_ff + PTR_W'(1);
            active_in = 1'b0;
            cursor_in = NULL_PTR;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register: a finished result waits here while the next transaction is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NULL_PTR;
         used_ff      <= '0;
         cursor_ff    <= NULL_PTR;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         used_ff      <= used_in;
         cursor_ff    <= cursor_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_ff <= req_data;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (val_we) val_mem[val_waddr] <= val_wdata;
      if (val_re) val_q <= val_mem[val_raddr];
   end

   always_ff @(posedge clock) begin
      if (lnk_we) lnk_mem[lnk_waddr] <= lnk_wdata;
      if (lnk_re) lnk_q <= lnk_mem[lnk_raddr];
   end

`ifndef SYNTHESIS
   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      int'(used_ff) <= int'(DEPTH))
      else $error("allocator count beyond store depth");

   a_head_allocated: assert property (@(posedge clock) disable iff (reset)
      head_ff == NULL_PTR || head_ff < used_ff)
      else $error("head names an unallocated node");

   a_cursor_allocated: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> cursor_ff < used_ff)
      else $error("active walk cursor names an unallocated node");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_EXEC)
      else $error("accepted transaction not executed");
`endif

endmodule
